/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* rtl/pfc_pkg.sv */
// ---------------------------------------------------------------------------
// Path format classifier package
// Types, character constants and the per-byte voting and decision functions.
// ---------------------------------------------------------------------------
package pfc_pkg;

  // Longest name that the byte position tracks before it saturates.
  localparam int MAX_NAME = 4096;
  localparam int POS_W    = $clog2(MAX_NAME + 1);

  // Vote counters saturate at their all-ones value.
  localparam int VOTE_W = 13;
  localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};

  // Characters and masks that the classification looks at.
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] MASK_CONT      = 8'hC0;
  localparam logic [7:0] CODE_CONT      = 8'h80;
  localparam logic [7:0] MASK_LEAD2     = 8'hE0;
  localparam logic [7:0] CODE_LEAD2     = 8'hC0;
  localparam logic [7:0] MASK_LEAD3     = 8'hF0;
  localparam logic [7:0] CODE_LEAD3     = 8'hE0;
  localparam logic [7:0] MASK_LEAD4     = 8'hF8;
  localparam logic [7:0] CODE_LEAD4     = 8'hF0;

  // Which counter one classified byte bumps.
  typedef enum logic [1:0] {
    VOTE_NONE  = 2'd0,
    VOTE_SLASH = 2'd1,
    VOTE_COLON = 2'd2,
    VOTE_DRIVE = 2'd3
  } vote_t;

  // Reported format of a path name.
  typedef enum logic [1:0] {
    PATH_UNKNOWN = 2'd0,
    PATH_SLASH   = 2'd1,
    PATH_COLON   = 2'd2,
    PATH_DRIVE   = 2'd3
  } path_type_t;

  // One input item as it travels from the input register to the core.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } pfc_item_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MASK_CONT) == CODE_CONT;
  endfunction

  // Classify byte c given the three bytes after it. at_two is set when c
  // sits at index two of the name, where a colon marks a drive letter.
  function automatic vote_t classify(input logic [7:0] c, input logic [7:0] a1,
                                     input logic [7:0] a2, input logic [7:0] a3,
                                     input logic at_two);
    vote_t v;
    v = VOTE_NONE;
    if (c == CHAR_SLASH) begin
      v = VOTE_SLASH;
    end else if (c == CHAR_COLON) begin
      v = at_two ? VOTE_DRIVE : VOTE_COLON;
    end else if (c == CHAR_BACKSLASH) begin
      v = VOTE_DRIVE;
    end else if ((c & MASK_LEAD2) == CODE_LEAD2 && is_cont(a1)) begin
      v = VOTE_SLASH;
    end else if ((c & MASK_LEAD3) == CODE_LEAD3 && is_cont(a1) && is_cont(a2)) begin
      v = VOTE_SLASH;
    end else if ((c & MASK_LEAD4) == CODE_LEAD4 && is_cont(a1) && is_cont(a2)
                 && is_cont(a3)) begin
      v = VOTE_SLASH;
    end else if (c[7]) begin
      v = VOTE_COLON;
    end
    return v;
  endfunction

  // Pick the format from the three counters with the fixed tie-break order.
  function automatic path_type_t decide(input logic [VOTE_W-1:0] u,
                                        input logic [VOTE_W-1:0] m,
                                        input logic [VOTE_W-1:0] d);
    path_type_t t;
    priority if (u > d && u > m) t = PATH_SLASH;
    else if (m > u && m > d)     t = PATH_COLON;
    else if (d > u && d > m)     t = PATH_DRIVE;
    else if (m > u)              t = PATH_COLON;
    else if (u > m)              t = PATH_SLASH;
    else if (m > d)              t = PATH_COLON;
    else if (u > d)              t = PATH_SLASH;
    else if (d > u)              t = PATH_DRIVE;
    else                         t = PATH_UNKNOWN;
    return t;
  endfunction

endpackage

/* rtl/path_format_classifier_unit.sv */
// ---------------------------------------------------------------------------
// Path format classifier unit
// Guesses the format of a path name streamed in one byte per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte of a path name per transfer, with
//   s_tlast on the final byte. A zero byte ends the name early; later bytes
//   up to the one with s_tlast are ignored. Only the transfer with s_tlast
//   gives a result on the master channel: the path type in m_tdata[1:0].
// Pipeline:
//   A byte is classified and counted as it leaves the input register; the
//   window shift, counter updates and decision share that one stage, so a
//   result enters the output register as its name-ending byte leaves, and
//   one byte per cycle is sustained while no name-ending byte is waiting.
// Reset:
//   rst clears the core state and both valid flags and holds s_tready low.
// Stalls:
//   A waiting result holds in the output register; bytes that do not end a
//   name keep flowing. A name-ending byte waits in the input register, with
//   s_tready low, until the output register frees.
// ---------------------------------------------------------------------------
module path_format_classifier_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] path_type, [7:2] zero
);
  import pfc_pkg::*;

  logic       in_valid;
  pfc_item_t  in_item;
  logic       out_valid;
  path_type_t out_type;
  logic       advance;
  path_type_t core_result;

  // The held byte moves on unless it ends a name and the result slot is full and not being read.
  assign advance  = in_valid && (!in_item.last || !out_valid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.char_byte <= s_tdata;
      in_item.last      <= s_tlast;
    end
  end

  pfc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_item.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.last) begin
      out_type <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_type};

endmodule

/* rtl/pfc_core.sv */
// ---------------------------------------------------------------------------
// Path format classifier core
// Holds the lookahead window and vote counters and updates them per byte.
// ---------------------------------------------------------------------------
module pfc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  pfc_pkg::pfc_item_t item,
  output pfc_pkg::path_type_t result
);
  import pfc_pkg::*;

  logic [7:0]        window [3];
  logic [POS_W-1:0]  pos;
  logic [VOTE_W-1:0] slash_votes;
  logic [VOTE_W-1:0] colon_votes;
  logic [VOTE_W-1:0] backslash_votes;
  logic              name_ended;

  logic [1:0]        pend;
  logic              push;
  logic              flush;
  vote_t             push_vote;
  logic [7:0]        win_next [3];
  logic [POS_W-1:0]  pos_next;
  logic [7:0]        fw [3];
  logic [POS_W-1:0]  pos_f;
  logic [1:0]        pend_f;
  logic [7:0]        fw2;
  vote_t             flush_vote0;
  vote_t             flush_vote1;
  logic [1:0]        inc_slash;
  logic [1:0]        inc_colon;
  logic [1:0]        inc_drive;
  logic [VOTE_W-1:0] slash_next;
  logic [VOTE_W-1:0] colon_next;
  logic [VOTE_W-1:0] drive_next;

  function automatic logic [VOTE_W-1:0] sat_add(input logic [VOTE_W-1:0] v,
                                                input logic [1:0] inc);
    logic [VOTE_W:0] sum;
    sum = {1'b0, v} + {{(VOTE_W-1){1'b0}}, inc};
    return (sum > {1'b0, VOTE_MAX}) ? VOTE_MAX : sum[VOTE_W-1:0];
  endfunction

  function automatic logic [1:0] count_of(input vote_t k, input vote_t a,
                                          input vote_t b, input vote_t c);
    return {1'b0, a == k} + {1'b0, b == k} + {1'b0, c == k};
  endfunction

  // Bytes held in the window: the position, capped at three.
  assign pend  = (pos >= POS_W'(3)) ? 2'd3 : pos[1:0];
  assign push  = !name_ended && (item.char_byte != 8'h00);
  assign flush = !name_ended && ((item.char_byte == 8'h00) || item.last);

  // A full window hands its oldest byte to the voter as the new byte arrives.
  always_comb begin
    push_vote = VOTE_NONE;
    win_next  = window;
    if (pend == 2'd3) begin
      if (push) begin
        push_vote = classify(window[0], window[1], window[2], item.char_byte,
                             pos == POS_W'(5));
      end
      win_next[0] = window[1];
      win_next[1] = window[2];
      win_next[2] = item.char_byte;
    end else begin
      win_next[pend] = item.char_byte;
    end
    pos_next = (pos == POS_W'(MAX_NAME)) ? pos : pos + POS_W'(1);
  end

  // At the end of the name, every held byte but the newest votes, with zeros
  // read past the end.
  always_comb begin
    if (push) begin
      fw    = win_next;
      pos_f = pos_next;
    end else begin
      fw    = window;
      pos_f = pos;
    end
    pend_f = (pos_f >= POS_W'(3)) ? 2'd3 : pos_f[1:0];
    fw2    = (pend_f == 2'd3) ? fw[2] : 8'h00;
    flush_vote0 = VOTE_NONE;
    flush_vote1 = VOTE_NONE;
    if (flush && pend_f >= 2'd2) begin
      flush_vote0 = classify(fw[0], fw[1], fw2, 8'h00,
                             (pend_f == 2'd3) && (pos_f == POS_W'(5)));
    end
    if (flush && pend_f == 2'd3) begin
      flush_vote1 = classify(fw[1], fw2, 8'h00, 8'h00, pos_f == POS_W'(4));
    end
  end

  // Counter updates and the decision on the updated counts.
  always_comb begin
    inc_slash  = count_of(VOTE_SLASH, push_vote, flush_vote0, flush_vote1);
    inc_colon  = count_of(VOTE_COLON, push_vote, flush_vote0, flush_vote1);
    inc_drive  = count_of(VOTE_DRIVE, push_vote, flush_vote0, flush_vote1);
    slash_next = sat_add(slash_votes, inc_slash);
    colon_next = sat_add(colon_votes, inc_colon);
    drive_next = sat_add(backslash_votes, inc_drive);
    result     = decide(slash_next, colon_next, drive_next);
  end

  // State registers; the last byte of a name returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      window          <= '{8'h00, 8'h00, 8'h00};
      pos             <= '0;
      slash_votes     <= '0;
      colon_votes     <= '0;
      backslash_votes <= '0;
      name_ended      <= 1'b0;
    end else if (step) begin
      if (push) begin
        window <= win_next;
        pos    <= pos_next;
      end
      slash_votes     <= slash_next;
      colon_votes     <= colon_next;
      backslash_votes <= drive_next;
      name_ended      <= name_ended || flush;
    end
  end

endmodule

/* rtl/pfc_checker.sv */
// ---------------------------------------------------------------------------
// Path format classifier checker
// Port-level checks on the classifier unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A stalled result holds its value.
  `ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

  // Reset takes no byte and leaves no result pending after it.
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |-> (!s_tready ##1 !m_tvalid))

  // A fresh result follows a name-ending transfer through the input and output registers.
  `ASSERT_CLK(a_result_source, clk, rst, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))

  // Only the two type bits of the result may be set.
  `ASSERT_CLK(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[7:2] == 6'b000000))

  // An empty result slot never blocks the input side.
  `ASSERT_CLK(a_ready_when_empty, clk, rst, (!m_tvalid && $past(!s_tvalid) && !$past(rst)) |-> s_tready)

endmodule

bind path_format_classifier_unit pfc_checker u_pfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Path format classifier testbench
// Streams path names into the classifier one byte per transfer and checks
// each reported path type against a cycle-free predictor of the vote counts.
// A short directed set comes first, then random names under three idle
// patterns with a long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import pfc_pkg::*;

  localparam int LIMIT_CYCLES  = 50000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ONE_END = 380;
  localparam int PHASE_TWO_END = 760;
  localparam int RANDOM_ITEMS  = 1150;

  // Which side idles often in the current part of the run.
  typedef enum int {
    IDLE_RX_HEAVY,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  // One pending byte with the pacing that goes with it.
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         pause;
    bit         hold;
    idle_mode_t mode;
  } path_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  path_byte_t pending_bytes[$];
  path_type_t expected_types[$];
  idle_mode_t mode = IDLE_RX_HEAVY;
  idle_mode_t gen_mode = IDLE_RX_HEAVY;
  bit         pend_pause = 1'b0;
  bit         pend_hold = 1'b0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  int         names_predicted = 0;
  int         results_seen = 0;
  int         random_items = 0;
  int         mismatches = 0;
  int         cycle = 0;

  // Predictor state: the unclassified bytes, position and the three tallies.
  logic [7:0]        la_win[3];
  int                name_pos;
  logic [VOTE_W-1:0] tally_slash;
  logic [VOTE_W-1:0] tally_colon;
  logic [VOTE_W-1:0] tally_drive;
  bit                name_done;

  path_format_classifier_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int send_idle_pct(input idle_mode_t m);
    case (m)
      IDLE_RX_HEAVY: return 13;
      IDLE_TX_HEAVY: return 76;
      default:       return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(input idle_mode_t m);
    case (m)
      IDLE_RX_HEAVY: return 76;
      IDLE_TX_HEAVY: return 13;
      default:       return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle, what);
    mismatches++;
  endtask

  function automatic bit cont_byte(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Which tally a byte feeds, given the three bytes after it.
  function automatic vote_t judge_byte(input logic [7:0] c, input logic [7:0] a1,
                                       input logic [7:0] a2, input logic [7:0] a3,
                                       input int idx);
    bit lead_ok;
    lead_ok = ((c & MASK_LEAD2) == CODE_LEAD2 && cont_byte(a1))
           || ((c & MASK_LEAD3) == CODE_LEAD3 && cont_byte(a1) && cont_byte(a2))
           || ((c & MASK_LEAD4) == CODE_LEAD4 && cont_byte(a1) && cont_byte(a2)
               && cont_byte(a3));
    case (c)
      CHAR_SLASH:     return VOTE_SLASH;
      CHAR_COLON:     return (idx == 2) ? VOTE_DRIVE : VOTE_COLON;
      CHAR_BACKSLASH: return VOTE_DRIVE;
      default: begin
        if (lead_ok) return VOTE_SLASH;
        if (c[7]) return VOTE_COLON;
        return VOTE_NONE;
      end
    endcase
  endfunction

  // Tallies stop at their all-ones value.
  task automatic add_vote(input vote_t v);
    case (v)
      VOTE_SLASH: if (tally_slash != VOTE_MAX) tally_slash++;
      VOTE_COLON: if (tally_colon != VOTE_MAX) tally_colon++;
      VOTE_DRIVE: if (tally_drive != VOTE_MAX) tally_drive++;
      default: ;
    endcase
  endtask

  // Classify what is still in the window except its newest byte.
  task automatic close_name();
    logic [7:0] tail[6];
    int held;
    held = (name_pos < 3) ? name_pos : 3;
    foreach (tail[k]) tail[k] = 8'h00;
    for (int k = 0; k < held; k++) tail[k] = la_win[k];
    for (int k = 0; k + 1 < held; k++)
      add_vote(judge_byte(tail[k], tail[k+1], tail[k+2], tail[k+3], name_pos - held + k));
    name_done = 1'b1;
  endtask

  task automatic take_byte(input logic [7:0] b);
    int held;
    held = (name_pos < 3) ? name_pos : 3;
    if (held == 3) begin
      add_vote(judge_byte(la_win[0], la_win[1], la_win[2], b, name_pos - 3));
      la_win[0] = la_win[1];
      la_win[1] = la_win[2];
      la_win[2] = b;
    end else begin
      la_win[held] = b;
    end
    if (name_pos < MAX_NAME) name_pos++;
  endtask

  function automatic path_type_t pick_format(input logic [VOTE_W-1:0] u,
                                             input logic [VOTE_W-1:0] m,
                                             input logic [VOTE_W-1:0] d);
    if (u > d && u > m) return PATH_SLASH;
    if (m > u && m > d) return PATH_COLON;
    if (d > u && d > m) return PATH_DRIVE;
    if (m > u) return PATH_COLON;
    if (u > m) return PATH_SLASH;
    if (m > d) return PATH_COLON;
    if (u > d) return PATH_SLASH;
    if (d > u) return PATH_DRIVE;
    return PATH_UNKNOWN;
  endfunction

  task automatic clear_name();
    foreach (la_win[k]) la_win[k] = 8'h00;
    name_pos    = 0;
    tally_slash = '0;
    tally_colon = '0;
    tally_drive = '0;
    name_done   = 1'b0;
  endtask

  // Update the predictor with one accepted byte; a final byte yields a type.
  task automatic track_name_byte(input logic [7:0] b, input logic fin);
    if (!name_done) begin
      if (b == 8'h00) begin
        close_name();
      end else begin
        take_byte(b);
        if (fin) close_name();
      end
    end
    if (fin) begin
      expected_types.push_back(pick_format(tally_slash, tally_colon, tally_drive));
      names_predicted++;
      clear_name();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    path_byte_t it;
    it.ch    = b;
    it.fin   = fin;
    it.pause = pend_pause;
    it.hold  = pend_hold;
    it.mode  = gen_mode;
    pend_pause = 1'b0;
    pend_hold  = 1'b0;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) queue_byte(s[k], k == s.len() - 1);
  endtask

  // A random name built from separators, UTF-8 sequences and plain bytes,
  // sometimes cut short by a zero byte.
  task automatic queue_random_name();
    logic [7:0] nm[$];
    int len;
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 70) len = $urandom_range(8, 1);
    else if (pick < 95) len = $urandom_range(30, 9);
    else len = $urandom_range(200, 31);
    // Drive letter with the colon at index two.
    if ($urandom_range(9) == 0) begin
      nm.push_back(8'h41 + 8'($urandom_range(25)));
      nm.push_back(8'($urandom_range(255, 1)));
      nm.push_back(CHAR_COLON);
    end
    while (nm.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        nm.push_back(CHAR_SLASH);
      end else if (pick < 25) begin
        nm.push_back(CHAR_COLON);
      end else if (pick < 35) begin
        nm.push_back(CHAR_BACKSLASH);
      end else if (pick < 45) begin
        nm.push_back({3'b110, 5'($urandom)});
        nm.push_back({2'b10, 6'($urandom)});
      end else if (pick < 52) begin
        nm.push_back({4'b1110, 4'($urandom)});
        repeat (2) nm.push_back({2'b10, 6'($urandom)});
      end else if (pick < 58) begin
        nm.push_back({5'b11110, 3'($urandom)});
        repeat (3) nm.push_back({2'b10, 6'($urandom)});
      end else if (pick < 64) begin
        // Lead byte without its continuation bytes.
        nm.push_back({2'b11, 6'($urandom)});
      end else if (pick < 70) begin
        nm.push_back({2'b10, 6'($urandom)});
      end else begin
        nm.push_back(8'($urandom_range(255, 1)));
      end
    end
    while (nm.size() > len) void'(nm.pop_back());
    if ($urandom_range(19) == 0) begin
      cut = $urandom_range(nm.size() - 1);
      nm[cut] = 8'h00;
    end
    for (int k = 0; k < nm.size(); k++) queue_byte(nm[k], k == nm.size() - 1);
    random_items += nm.size();
  endtask

  // Sender: offers the next pending byte unless idling or waiting to drain.
  always @(posedge clk) begin
    path_byte_t nxt;
    logic launch;
    launch = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      hold_req <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_name_byte(s_tdata, s_tlast);
      if ((!s_tvalid || s_tready) && pending_bytes.size() != 0
          && $urandom_range(99) >= send_idle_pct(mode)
          && (!pending_bytes[0].pause || names_predicted == results_seen)) begin
        launch = 1'b1;
        nxt = pending_bytes.pop_front();
      end
      if (launch) begin
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.ch;
        s_tlast  <= nxt.fin;
        mode     <= nxt.mode;
      end else if (!s_tvalid || s_tready) begin
        s_tvalid <= 1'b0;
      end
      hold_req <= launch && nxt.hold;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct(mode));
    end
  end

  // Result checker: each transfer is compared with the oldest predicted type.
  always @(posedge clk) begin
    path_type_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_types.size() == 0) begin
        report_mismatch($sformatf("result %0h with no name pending", m_tdata));
      end else begin
        want = expected_types.pop_front();
        if (m_tdata[1:0] !== want)
          report_mismatch($sformatf("path_type %0d, predicted %0d", m_tdata[1:0], want));
        if (m_tdata[7:2] !== 6'd0)
          report_mismatch($sformatf("padding bits %0h not zero", m_tdata[7:2]));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clear_name();

    // Directed names: empty, single byte, drive colon, a three-way tie,
    // UTF-8 leads of every length, and names ended by a zero byte.
    gen_mode = IDLE_RX_HEAVY;
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_text("ab:c");
    queue_text(":/\\x");
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_text("\\/");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_text("::");
    queue_byte(8'h00, 1'b1);

    while (random_items < PHASE_ONE_END) queue_random_name();
    pend_pause = 1'b1;
    gen_mode = IDLE_TX_HEAVY;
    while (random_items < PHASE_TWO_END) queue_random_name();
    pend_pause = 1'b1;
    gen_mode = IDLE_NONE;
    while (random_items < PHASE_TWO_END + 40) queue_random_name();
    pend_hold = 1'b1;
    while (random_items < RANDOM_ITEMS) queue_random_name();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (names_predicted != results_seen) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_types.size() != 0)
      report_mismatch($sformatf("%0d predicted types never arrived", expected_types.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
